@@ src/lsf_pkg.sv @@
// ---------------------------------------------------------------------------
// lsf_pkg: shared types and constants for the line substring filter
// Result and queue entry layouts, configuration register indexes and the
// pattern byte select used by the tail comparator.
// ---------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  localparam int PAT_BYTES = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LINE_NUM_W = 32;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic RPT_LINE   = 1'b0;
  localparam logic RPT_STATUS = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_INVERT       = 3'd3,
    REG_NUMBER_LINES = 3'd4,
    REG_QUIET        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [4:0]             pattern_length;
    logic                   invert_select;
    logic                   number_lines;
    logic                   quiet_mode;
  } cfg_t;

  typedef struct packed {
    logic                  report_kind;
    logic [LINE_NUM_W-1:0] line_number;
    logic                  print_text;
    logic                  exit_status;
    logic                  last_result;
  } result_t;

  // One queue entry carries every result of one input transfer.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  // Positions past the configured pattern storage read as zero.
  function automatic logic [7:0] pattern_byte(input logic [8*PAT_BYTES-1:0] pat,
                                              input logic [4:0] pos);
    logic [7:0] b;
    b = 8'd0;
    if (pos < 5'(PAT_BYTES)) begin
      b = pat[{pos[3:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ src/lsf_match.sv @@
// ---------------------------------------------------------------------------
// lsf_match: tail comparator
// Checks whether the newest bytes of the current line end with the pattern.
// ---------------------------------------------------------------------------
`default_nettype none

module lsf_match
  import lsf_pkg::*;
#(
  parameter int PATTERN_MAX = 16,
  parameter int BW = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [PATTERN_MAX-1:0][7:0] recent,
  input  wire logic [BW-1:0]               bytes_in_line,
  input  wire logic [8*PAT_BYTES-1:0]      pattern,
  input  wire logic [4:0]                  pattern_length,
  output logic                             hit
);

  localparam int CW = (BW > 5) ? BW : 5;

  logic [CW-1:0]          len_c;
  logic [CW-1:0]          bil_c;
  logic [PATTERN_MAX-1:0] pos_ok;

  assign len_c = CW'(pattern_length);
  assign bil_c = CW'(bytes_in_line);

  // Byte k places back must equal pattern byte len-1-k.
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (CW'(k) < len_c) begin
        pos_ok[k] = (recent[k] ==
                     pattern_byte(pattern, pattern_length - 5'd1 - 5'(k)));
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  always_comb begin
    if (pattern_length == 5'd0) begin
      hit = 1'b1;
    end else if (len_c > CW'(PATTERN_MAX) || bil_c < len_c) begin
      hit = 1'b0;
    end else begin
      hit = &pos_ok;
    end
  end

endmodule

`default_nettype wire

@@ src/lsf_core.sv @@
// ---------------------------------------------------------------------------
// lsf_core: input register and line state
// Holds one input transfer, updates the line state and builds the results.
// ---------------------------------------------------------------------------
`default_nettype none

module lsf_core
  import lsf_pkg::*;
#(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_COUNT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_stream,
  input  wire cfg_t       cfg,
  input  wire logic       room,
  output logic            push,
  output bundle_t         bundle
);

  localparam int BW = $clog2(PATTERN_MAX + 1);

  logic                             a_valid_r, a_valid_nxt;
  logic [7:0]                       a_byte_r;
  logic                             a_eos_r;
  logic [PATTERN_MAX-1:0][7:0]      recent_r, recent_nxt, recent_shift;
  logic [BW-1:0]                    bil_r, bil_nxt, bil_inc;
  logic                             open_r, open_nxt;
  logic                             matched_r, matched_nxt;
  logic                             any_r, any_nxt;
  logic [LINE_COUNT_BITS-1:0]       cnt_r, cnt_nxt, cnt_inc;

  logic    load, fire, tail_hit, closing, matched_line, selected, line_emit;
  logic    any_after;
  result_t line_res, status_res;

  assign fire     = a_valid_r && room;
  assign in_stall = a_valid_r && !room;
  assign load     = in_valid && !in_stall;

  always_comb begin
    recent_shift[0] = a_byte_r;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      recent_shift[k] = recent_r[k-1];
    end
  end

  assign bil_inc = (bil_r == BW'(PATTERN_MAX)) ? bil_r : bil_r + BW'(1);
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + LINE_COUNT_BITS'(1);

  lsf_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .BW          (BW)
  ) u_match (
    .recent         (recent_shift),
    .bytes_in_line  (bil_inc),
    .pattern        (cfg.pattern),
    .pattern_length (cfg.pattern_length),
    .hit            (tail_hit)
  );

  assign closing      = a_eos_r ? open_r : (a_byte_r == NEWLINE_BYTE);
  assign matched_line = a_eos_r ? matched_r : (matched_r | tail_hit);
  assign selected     = matched_line ^ cfg.invert_select;
  assign line_emit    = closing && selected && !cfg.quiet_mode;
  assign any_after    = any_r | (closing & selected);

  always_comb begin
    line_res.report_kind   = RPT_LINE;
    line_res.line_number   = LINE_NUM_W'(cnt_inc);
    line_res.print_text    = !cfg.number_lines;
    line_res.exit_status   = 1'b0;
    line_res.last_result   = !a_eos_r;

    status_res.report_kind = RPT_STATUS;
    status_res.line_number = '0;
    status_res.print_text  = 1'b0;
    status_res.exit_status = !any_after;
    status_res.last_result = 1'b1;
  end

  always_comb begin
    a_valid_nxt = load ? 1'b1 : (fire ? 1'b0 : a_valid_r);
    recent_nxt  = recent_r;
    bil_nxt     = bil_r;
    open_nxt    = open_r;
    matched_nxt = matched_r;
    any_nxt     = any_r;
    cnt_nxt     = cnt_r;
    push        = 1'b0;
    bundle.two  = 1'b0;
    bundle.r0   = line_res;
    bundle.r1   = status_res;
    if (fire) begin
      if (a_eos_r) begin
        // End of stream: close any open line, report status, start afresh.
        recent_nxt  = '0;
        bil_nxt     = '0;
        open_nxt    = 1'b0;
        matched_nxt = 1'b0;
        any_nxt     = 1'b0;
        cnt_nxt     = '0;
        push        = 1'b1;
        if (line_emit) begin
          bundle.two = 1'b1;
        end else begin
          bundle.r0 = status_res;
        end
      end else begin
        recent_nxt = recent_shift;
        if (a_byte_r == NEWLINE_BYTE) begin
          bil_nxt     = '0;
          open_nxt    = 1'b0;
          matched_nxt = 1'b0;
          cnt_nxt     = cnt_inc;
          any_nxt     = any_after;
          push        = line_emit;
        end else begin
          bil_nxt     = bil_inc;
          open_nxt    = 1'b1;
          matched_nxt = matched_line;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      recent_r  <= '0;
      bil_r     <= '0;
      open_r    <= 1'b0;
      matched_r <= 1'b0;
      any_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      recent_r  <= recent_nxt;
      bil_r     <= bil_nxt;
      open_r    <= open_nxt;
      matched_r <= matched_nxt;
      any_r     <= any_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_byte_r <= in_text_byte;
      a_eos_r  <= in_end_of_stream;
    end
  end

endmodule

`default_nettype wire

@@ src/lsf_rq.sv @@
// ---------------------------------------------------------------------------
// lsf_rq: result queue
// Small queue of result bundles; drains one result per output transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module lsf_rq
  import lsf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t bundle,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      head_res
);

  bundle_t               mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [RQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  sub_r, sub_nxt;
  bundle_t               head;
  logic                  xfer, pop;

  assign room      = (cnt_r != RQ_CNT_W'(RQ_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign head      = mem[rp_r];
  assign head_res  = sub_r ? head.r1 : head.r0;
  assign xfer      = out_valid && !out_stall;
  // Advance to the second result of a bundle before dropping the entry.
  assign pop       = xfer && (sub_r || !head.two);

  always_comb begin
    wp_nxt  = push ? wp_r + RQ_PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + RQ_PTR_W'(1) : rp_r;
    sub_nxt = xfer ? !pop : sub_r;
    cnt_nxt = cnt_r + RQ_CNT_W'(push) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= bundle;
    end
  end

endmodule

`default_nettype wire

@@ src/line_substring_filter.sv @@
// ---------------------------------------------------------------------------
// line_substring_filter: fixed-string line search over a byte stream
// Scans text one byte per transfer and reports lines containing a pattern.
// ---------------------------------------------------------------------------
// Input channel: in_text_byte / in_end_of_stream with in_valid / in_stall.
// Output channel: one result per transfer, up to two per input transfer
// (a closing line report followed by the exit status at end of stream).
// Configuration: cfg_we writes register cfg_index with cfg_wdata; write
// only while the block is idle.
// Throughput: one input transfer per cycle while the queue has room; set by
// the single register stage holding the incoming byte and the tail compare
// behind it. End of stream with an open selected line adds a second result.
// Path: each input transfer is registered, then its results are written
// into the queue that drives the output channel once the queue has room.
// Results sit in a four-entry queue; when the receiver stalls, input keeps
// flowing until the queue fills, then in_stall rises.
// Reset clears configuration, line state, line counter and the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_end_of_stream,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_report_kind,
  output logic [LINE_NUM_W-1:0]      out_line_number,
  output logic                       out_print_text,
  output logic                       out_exit_status,
  output logic                       out_last_result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    room, push;
  bundle_t bundle;
  result_t head_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  cfg_r.pattern[63:0]   <= cfg_wdata;
        REG_PATTERN_HIGH: cfg_r.pattern[127:64] <= cfg_wdata;
        REG_PATTERN_LEN:  cfg_r.pattern_length  <= cfg_wdata[4:0];
        REG_INVERT:       cfg_r.invert_select   <= cfg_wdata[0];
        REG_NUMBER_LINES: cfg_r.number_lines    <= cfg_wdata[0];
        REG_QUIET:        cfg_r.quiet_mode      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  lsf_core #(
    .PATTERN_MAX     (PATTERN_MAX),
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_stream (in_end_of_stream),
    .cfg              (cfg_r),
    .room             (room),
    .push             (push),
    .bundle           (bundle)
  );

  lsf_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bundle    (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_res  (head_res)
  );

  assign out_report_kind = head_res.report_kind;
  assign out_line_number = head_res.line_number;
  assign out_print_text  = head_res.print_text;
  assign out_exit_status = head_res.exit_status;
  assign out_last_result = head_res.last_result;

endmodule

`default_nettype wire

@@ src/lsf_checker.sv @@
// ---------------------------------------------------------------------------
// lsf_checker: port-level checks for the line substring filter
// Watches the result channel and the shape of line and status results.
// ---------------------------------------------------------------------------
`default_nettype none

module lsf_checker
  import lsf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_report_kind,
  input wire logic [LINE_NUM_W-1:0] out_line_number,
  input wire logic                  out_print_text,
  input wire logic                  out_exit_status,
  input wire logic                  out_last_result
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_kind) &&
      $stable(out_line_number) && $stable(out_print_text) &&
      $stable(out_exit_status) && $stable(out_last_result))
    else $error("stalled result changed");

  // A status result is always the last one of its transfer and carries no line.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == RPT_STATUS |->
      out_last_result && !out_print_text && out_line_number == '0)
    else $error("malformed status result");

  // Line reports carry a clear exit status and a nonzero line number.
  a_line_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == RPT_LINE |->
      !out_exit_status && out_line_number != '0)
    else $error("malformed line result");

  // A line report that is not last must be followed by the status result.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_report_kind == RPT_LINE && !out_last_result |=>
      out_valid && out_report_kind == RPT_STATUS)
    else $error("status result missing after closing line");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (.*);

`default_nettype wire

@@ verif/line_substring_filter_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_substring_filter_checker: result predictor and comparator
// Watches the configuration port and both channels of the line filter,
// keeps its own copy of the filter state, queues the line and status
// reports that each input transfer should cause and compares every result
// transfer with the oldest queued report.
// ---------------------------------------------------------------------------
module line_substring_filter_checker
  import lsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_end_of_stream,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_report_kind,
  input  logic [LINE_NUM_W-1:0] out_line_number,
  input  logic                  out_print_text,
  input  logic                  out_exit_status,
  input  logic                  out_last_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fails,
  output int                    pending
);

  // filter settings as last written
  logic [8*PAT_BYTES-1:0] pat_cfg;
  logic [4:0]             pat_len;
  logic                   invert_cfg;
  logic                   number_cfg;
  logic                   quiet_cfg;

  // line scanner state
  logic [7:0]            recent [PAT_BYTES];
  logic [4:0]            line_fill;
  logic                  line_open;
  logic                  line_hit;
  logic [LINE_NUM_W-1:0] line_count;
  logic                  any_selected;

  result_t step_reports [2];
  int      step_count;
  result_t expected_reports [$];

  function automatic result_t make_report(logic kind, logic [LINE_NUM_W-1:0] num,
                                          logic text, logic status);
    result_t r;
    r.report_kind = kind;
    r.line_number = num;
    r.print_text  = text;
    r.exit_status = status;
    r.last_result = 1'b0;
    return r;
  endfunction

  // The newest byte lines up with the last pattern byte.
  function automatic logic tail_hit();
    int  plen;
    logic hit;
    plen = int'(pat_len);
    hit  = 1'b1;
    if (plen == 0) return 1'b1;
    if (plen > PAT_BYTES || int'(line_fill) < plen) return 1'b0;
    for (int k = 0; k < plen; k++) begin
      if (recent[k] != pat_cfg[8*(plen-1-k) +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic close_line();
    if (line_count != '1) line_count++;
    if (line_hit != invert_cfg) begin
      any_selected = 1'b1;
      if (!quiet_cfg) begin
        step_reports[step_count] = make_report(RPT_LINE, line_count, ~number_cfg, 1'b0);
        step_count++;
      end
    end
    line_fill = '0;
    line_open = 1'b0;
    line_hit  = 1'b0;
  endtask

  task automatic scan_transfer(logic [7:0] b, logic eos);
    step_count = 0;
    if (eos) begin
      if (line_open) close_line();
      step_reports[step_count] = make_report(RPT_STATUS, '0, 1'b0, ~any_selected);
      step_count++;
      line_count   = '0;
      any_selected = 1'b0;
      foreach (recent[i]) recent[i] = 8'd0;
    end else begin
      for (int i = PAT_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (line_fill < 5'(PAT_BYTES)) line_fill++;
      line_open = 1'b1;
      if (tail_hit()) line_hit = 1'b1;
      if (b == NEWLINE_BYTE) close_line();
    end
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_reports[i].last_result = 1'b1;
      expected_reports.push_back(step_reports[i]);
    end
  endtask

  task automatic check_field(string name, logic [LINE_NUM_W-1:0] want,
                             logic [LINE_NUM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      pat_cfg      = '0;
      pat_len      = '0;
      invert_cfg   = 1'b0;
      number_cfg   = 1'b0;
      quiet_cfg    = 1'b0;
      foreach (recent[i]) recent[i] = 8'd0;
      line_fill    = '0;
      line_open    = 1'b0;
      line_hit     = 1'b0;
      line_count   = '0;
      any_selected = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LOW:  pat_cfg[63:0]   = cfg_wdata;
          REG_PATTERN_HIGH: pat_cfg[127:64] = cfg_wdata;
          REG_PATTERN_LEN:  pat_len         = cfg_wdata[4:0];
          REG_INVERT:       invert_cfg      = cfg_wdata[0];
          REG_NUMBER_LINES: number_cfg      = cfg_wdata[0];
          REG_QUIET:        quiet_cfg       = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_transfer(in_text_byte, in_end_of_stream);
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d line %0d status %0d",
                 out_report_kind, out_line_number, out_exit_status);
          fails++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", LINE_NUM_W'(want.report_kind),
                      LINE_NUM_W'(out_report_kind));
          check_field("line_number", want.line_number, out_line_number);
          check_field("print_text", LINE_NUM_W'(want.print_text),
                      LINE_NUM_W'(out_print_text));
          check_field("exit_status", LINE_NUM_W'(want.exit_status),
                      LINE_NUM_W'(out_exit_status));
          check_field("last_result", LINE_NUM_W'(want.last_result),
                      LINE_NUM_W'(out_last_result));
        end
      end
    end
    pending <= expected_reports.size();
  end

endmodule

@@ verif/line_substring_filter_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_substring_filter_tb: regression bench for the line substring filter
// Drives byte streams under a series of pattern and mode settings, with
// random idle bursts on both channels, and leaves result checking to the
// checker instance; ends with a single pass or fail verdict.
// ---------------------------------------------------------------------------
module line_substring_filter_tb;
  import lsf_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 425;
  localparam int CALM_FROM    = 340;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = 8'd0;
  logic                  in_end_of_stream = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_report_kind;
  logic [LINE_NUM_W-1:0] out_line_number;
  logic                  out_print_text;
  logic                  out_exit_status;
  logic                  out_last_result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fails;
  int pending;
  int sent = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;

  // pattern as last written, used to plant matches in the text
  logic [7:0] pat_bytes [PAT_BYTES];
  int         plen = 0;

  line_substring_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_kind  (out_report_kind),
    .out_line_number  (out_line_number),
    .out_print_text   (out_print_text),
    .out_exit_status  (out_exit_status),
    .out_last_result  (out_last_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  line_substring_filter_checker report_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_kind  (out_report_kind),
    .out_line_number  (out_line_number),
    .out_print_text   (out_print_text),
    .out_exit_status  (out_exit_status),
    .out_last_result  (out_last_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fails            (fails),
    .pending          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // random receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_gaps && !calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly a small alphabet so planted and chance matches are common
  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  task automatic send_item(logic [7:0] b, logic eos);
    if (in_gaps && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_text_byte     <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drop valid, wait out every expected report and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // upper bits of narrow registers carry junk that the block must drop
  task automatic set_filter(logic [8*PAT_BYTES-1:0] pat, logic [4:0] len,
                            logic inv, logic num, logic quiet);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LEN, {junk[63:5], len});
    write_reg(REG_INVERT, {junk[63:1], inv});
    write_reg(REG_NUMBER_LINES, {junk[62:0], num});
    write_reg(REG_QUIET, {junk[63:2], junk[0], quiet});
    cfg_we <= 1'b0;
    for (int i = 0; i < PAT_BYTES; i++) pat_bytes[i] = pat[8*i +: 8];
    plen = int'(len);
  endtask

  // lines of random text, about half with the pattern planted somewhere
  task automatic random_phase(int budget);
    int start;
    int len;
    int at;
    bit plant;
    start = sent;
    while (sent - start < budget) begin
      len   = $urandom_range(0, 12);
      at    = $urandom_range(0, len);
      plant = (plen >= 1) && (plen <= PAT_BYTES) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i <= len; i++) begin
        if (plant && i == at) begin
          for (int j = 0; j < plen; j++) send_item(pat_bytes[j], 1'b0);
        end
        if (i < len) send_item(text_char(), 1'b0);
      end
      send_item(NEWLINE_BYTE, 1'b0);
    end
    // leave a line open at end of stream now and then
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 4)) send_item(text_char(), 1'b0);
    end
    send_item(8'($urandom), 1'b1);
    if ($urandom_range(0, 4) == 0) send_item(8'($urandom), 1'b1);
  endtask

  initial begin
    logic [8*PAT_BYTES-1:0] pat;
    logic [4:0]             len;
    int                     pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty pattern selects every line
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'hA5, 1'b1);
    send_item(NEWLINE_BYTE, 1'b0);
    settle();

    // pattern with a zero byte, numbers only
    set_filter(128'hFF_00_61, 5'd3, 1'b0, 1'b1, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h00, 1'b1);
    settle();

    // length past the pattern storage never matches; inverted and quiet
    set_filter('0, 5'd31, 1'b1, 1'b0, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'hFF, 1'b1);
    settle();

    set_filter('1, 5'd16, 1'b0, 1'b1, 1'b0);
    random_phase(40);
    settle();

    set_filter('0, 5'd0, 1'b0, 1'b0, 1'b0);
    random_phase(30);

    while (sent < ITEM_TARGET) begin
      settle();
      calm     = (sent >= CALM_FROM);
      in_gaps  = !calm && ($urandom_range(0, 3) != 0);
      out_gaps = !calm && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PAT_BYTES; i++) pat[8*i +: 8] = text_char();
      pick = $urandom_range(0, 19);
      if (pick < 2)       len = 5'd0;
      else if (pick < 12) len = 5'($urandom_range(1, 4));
      else if (pick < 18) len = 5'($urandom_range(5, 16));
      else                len = 5'($urandom_range(17, 31));
      set_filter(pat, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 4) == 0));
      random_phase($urandom_range(30, 60));
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
